// File: rtl/htcd_pkg.sv
// Package for the tree code and decode unit: sizes, beat structs and state codes.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps
package htcd_pkg;
  localparam int MaxSymbols = 16;
  localparam int WeightBits = 16;
  localparam int NodeCount  = 2 * MaxSymbols - 1;
  localparam int IdxW       = 6;
  localparam int LeafW      = 5;
  localparam int NodeWW     = WeightBits + 5;
  localparam logic [IdxW-1:0] NoNode = 6'h3F;

  localparam logic [1:0] KindCode = 2'd0;
  localparam logic [1:0] KindSym  = 2'd1;
  localparam logic [1:0] KindOk   = 2'd2;
  localparam logic [1:0] KindErr  = 2'd3;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqDecode = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] weight;
    logic        code_bit;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  symbol;
    logic [14:0] code_word;
    logic [3:0]  code_length;
    logic        final_result;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MERGE, ST_CODE, ST_EMIT, ST_DEC_END
  } state_t;
endpackage

// File: rtl/huffman_tree_code_and_decode_unit.sv
// Top level: holds the node tables and a sequencer that uses one comparator pair
// for the tree build, one walk step for code generation, and the decode walk. Uses htcd_pkg.
`timescale 1ns / 1ps
// Usage:
//  - Input beats are taken when start is high and busy is low; the payload is in_beat.
//  - A load beat without last is taken without leaving idle and returns nothing.
//  - A load beat with last starts the build: n-1 merges, each scanning every node
//    built so far one per cycle with the pair of weight comparators, then a commit
//    step per merge, after an initial merge step that commits nothing. The code state
//    then sets up the code walk, and each symbol's code entry is found by walking to
//    the root one level per cycle and is emitted once the root is reached. The last
//    entry has final_result set.
//  - A decode beat makes one tree step; it yields at most two results (a symbol,
//    then ok), and busy stays high while the second one is pending.
//  - Each result appears on out_beat for one cycle with out_valid high, starting
//    the cycle after the cycle that produced it; the receiver cannot stall.
//  - Synchronous active-low reset clears the state, leaf count, cursor, flags, output
//    valid and link tables; no tree exists afterwards, so decode beats return an error.
module huffman_tree_code_and_decode_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  htcd_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  output htcd_pkg::out_beat_t out_beat
);
  localparam int IW = htcd_pkg::IdxW;
  localparam int WW = htcd_pkg::NodeWW;
  localparam int NC = htcd_pkg::NodeCount;
  localparam int AW = $clog2(NC);

  htcd_pkg::state_t state_r, state_nxt;

  logic [WW-1:0] weight_r [NC];
  logic [IW-1:0] parent_r [NC];
  logic [IW-1:0] left_r   [NC];
  logic [IW-1:0] right_r  [NC];

  logic [htcd_pkg::LeafW-1:0] leaf_cnt_r;
  logic [IW-1:0] cursor_r;
  logic          ready_r, open_r;

  // Scan and walk registers.
  logic [IW-1:0] merge_r, scan_r, a_r, b_r, child_r, sym_r;
  logic [WW-1:0] w1_r, w2_r;
  logic          h1_r, h2_r;
  logic [14:0]   word_r;
  logic [3:0]    len_r;
  htcd_pkg::out_beat_t pend_beat_r;

  // Decode step signals.
  logic [IW-1:0] dc, nx;
  logic          dec_sym, pend_dec_two, dec_err_only;

  logic take;
  assign take = start && !busy;
  assign busy = (state_r != htcd_pkg::ST_IDLE);

  logic [IW-1:0] n_ext, root_idx;
  assign n_ext    = IW'(leaf_cnt_r);
  assign root_idx = IW'({n_ext, 1'b0} - IW'(2));

  // Parent of the node on the code walk.
  logic [IW-1:0] up_c;
  assign up_c = parent_r[child_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= htcd_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      htcd_pkg::ST_IDLE: begin
        if (take && in_beat.req_type == htcd_pkg::ReqLoad && in_beat.last)
          state_nxt = htcd_pkg::ST_MERGE;
        else if (take && in_beat.req_type == htcd_pkg::ReqDecode && pend_dec_two)
          state_nxt = htcd_pkg::ST_DEC_END;
      end
      htcd_pkg::ST_MERGE:   state_nxt = ((h2_r && merge_r + IW'(1) >= n_ext + n_ext - IW'(1))
                                        || n_ext < IW'(2)) ?
                                        htcd_pkg::ST_CODE : htcd_pkg::ST_SCAN;
      htcd_pkg::ST_SCAN:    state_nxt = (scan_r + IW'(1) >= merge_r) ?
                                        htcd_pkg::ST_MERGE : htcd_pkg::ST_SCAN;
      htcd_pkg::ST_CODE:    state_nxt = htcd_pkg::ST_EMIT;
      htcd_pkg::ST_EMIT:    state_nxt = (up_c == htcd_pkg::NoNode &&
                                         sym_r + IW'(1) >= n_ext) ?
                                        htcd_pkg::ST_IDLE : htcd_pkg::ST_EMIT;
      htcd_pkg::ST_DEC_END: state_nxt = htcd_pkg::ST_IDLE;
      default:              state_nxt = htcd_pkg::ST_IDLE;
    endcase
  end

  // Decode step, worked out combinationally from the cursor.
  always_comb begin
    dc = (cursor_r >= IW'(NC)) ? root_idx : cursor_r;
    nx = in_beat.code_bit ? right_r[dc[AW-1:0]] : left_r[dc[AW-1:0]];
    if (nx >= IW'(NC)) nx = root_idx;
    dec_err_only = !ready_r || open_r;
    dec_sym      = (leaf_cnt_r == htcd_pkg::LeafW'(1)) || (nx < n_ext);
    pend_dec_two = !dec_err_only && dec_sym && in_beat.last;
  end

  // Merge scan compare: the shared comparator pair against the two lightest so far.
  logic live, lt1, lt2;
  assign live = (parent_r[scan_r[AW-1:0]] == htcd_pkg::NoNode);
  assign lt1  = !h1_r || (weight_r[scan_r[AW-1:0]] < w1_r);
  assign lt2  = !h2_r || (weight_r[scan_r[AW-1:0]] < w2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_cnt_r <= '0;
      cursor_r   <= '0;
      ready_r    <= 1'b0;
      open_r     <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        parent_r[i] <= htcd_pkg::NoNode;
        left_r[i]   <= htcd_pkg::NoNode;
        right_r[i]  <= htcd_pkg::NoNode;
      end
    end else begin
      out_valid <= 1'b0;
      out_beat  <= '0;
      unique case (state_r)
        htcd_pkg::ST_IDLE: begin
          if (take && in_beat.req_type == htcd_pkg::ReqLoad) begin
            logic [htcd_pkg::LeafW-1:0] cnt;
            cnt = open_r ? leaf_cnt_r : '0;
            if (!open_r) begin
              for (int i = 0; i < NC; i++) begin
                parent_r[i] <= htcd_pkg::NoNode;
                left_r[i]   <= htcd_pkg::NoNode;
                right_r[i]  <= htcd_pkg::NoNode;
              end
              cursor_r <= '0;
              ready_r  <= 1'b0;
            end
            if (cnt < htcd_pkg::LeafW'(htcd_pkg::MaxSymbols)) begin
              weight_r[cnt[IW-2:0]] <= WW'(in_beat.weight[htcd_pkg::WeightBits-1:0]);
              cnt = cnt + htcd_pkg::LeafW'(1);
            end
            leaf_cnt_r <= cnt;
            open_r     <= !in_beat.last;
            merge_r    <= IW'(cnt);
            scan_r     <= '0;
            h1_r       <= 1'b0;
            h2_r       <= 1'b0;
          end else if (take) begin
            out_valid <= 1'b1;
            out_beat.final_result <= 1'b1;
            if (dec_err_only) begin
              out_beat.kind <= htcd_pkg::KindErr;
            end else begin
              if (dec_sym) begin
                out_beat.kind   <= htcd_pkg::KindSym;
                out_beat.symbol <= (leaf_cnt_r == htcd_pkg::LeafW'(1)) ? 4'd0 : nx[3:0];
                out_beat.final_result <= !in_beat.last;
                cursor_r <= root_idx;
              end else begin
                cursor_r <= nx;
                if (in_beat.last) begin
                  // A walk that is back at the root ends cleanly.
                  out_beat.kind <= (nx == root_idx) ? htcd_pkg::KindOk : htcd_pkg::KindErr;
                  cursor_r <= root_idx;
                end else begin
                  out_valid <= 1'b0;
                end
              end
              pend_beat_r <= '{kind: htcd_pkg::KindOk, symbol: 4'd0, code_word: 15'd0,
                               code_length: 4'd0, final_result: 1'b1};
            end
          end
        end
        htcd_pkg::ST_DEC_END: begin
          out_valid <= 1'b1;
          out_beat  <= pend_beat_r;
        end
        htcd_pkg::ST_MERGE: begin
          // Commit the pair found by the last scan (none before the first).
          if (merge_r > n_ext || (merge_r == n_ext && h2_r)) begin
            parent_r[a_r[AW-1:0]]     <= merge_r;
            parent_r[b_r[AW-1:0]]     <= merge_r;
            weight_r[merge_r[AW-1:0]] <= w1_r + w2_r;
            left_r[merge_r[AW-1:0]]   <= a_r;
            right_r[merge_r[AW-1:0]]  <= b_r;
          end
          if (h2_r) merge_r <= merge_r + IW'(1);
          scan_r <= '0;
          h1_r   <= 1'b0;
          h2_r   <= 1'b0;
          sym_r  <= '0;
        end
        htcd_pkg::ST_SCAN: begin
          if (live) begin
            if (lt1) begin
              b_r <= a_r; w2_r <= w1_r; h2_r <= h1_r;
              a_r <= scan_r; w1_r <= weight_r[scan_r[AW-1:0]]; h1_r <= 1'b1;
            end else if (lt2) begin
              b_r <= scan_r; w2_r <= weight_r[scan_r[AW-1:0]]; h2_r <= 1'b1;
            end
          end
          scan_r <= scan_r + IW'(1);
        end
        htcd_pkg::ST_CODE: begin
          ready_r  <= 1'b1;
          cursor_r <= root_idx;
          child_r  <= '0;
          word_r   <= '0;
          len_r    <= '0;
        end
        htcd_pkg::ST_EMIT: begin
          if (up_c == htcd_pkg::NoNode) begin
            out_valid <= 1'b1;
            out_beat  <= '{kind: htcd_pkg::KindCode, symbol: sym_r[3:0],
                           code_word: word_r, code_length: len_r,
                           final_result: (sym_r + IW'(1) >= n_ext)};
            sym_r   <= sym_r + IW'(1);
            child_r <= sym_r + IW'(1);
            word_r  <= '0;
            len_r   <= '0;
          end else begin
            if (left_r[up_c[AW-1:0]] != child_r &&
                right_r[up_c[AW-1:0]] == child_r)
              word_r <= word_r | (15'd1 << len_r);
            len_r   <= len_r + 4'd1;
            child_r <= up_c;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/htcd_checker.sv
// Port-level checker for the tree code and decode unit, bound to the top level.
// Depends on htcd_pkg.
`timescale 1ns / 1ps
module htcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input htcd_pkg::out_beat_t out_beat
);
  // A code entry is only produced while a build runs.
  a_code_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == htcd_pkg::KindCode |-> $past(busy))
    else $error("code entry outside build");
  // Ok and error beats end the item.
  a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_beat.kind == htcd_pkg::KindOk || out_beat.kind == htcd_pkg::KindErr)
    |-> out_beat.final_result)
    else $error("end beat not final");
  // Beats other than code entries carry no code length.
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind != htcd_pkg::KindCode |-> out_beat.code_length == 4'd0)
    else $error("stray code length");
endmodule

bind huffman_tree_code_and_decode_unit htcd_checker u_htcd_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_beat(out_beat));

// File: tb/sv/huffman_tree_code_and_decode_unit_tb.sv
// Self-checking bench for the tree code and decode unit: directed table, then random sets.
// Depends on htcd_pkg and the unit's top level; expected beats come from a local tree predictor.
`timescale 1ns / 1ps
module huffman_tree_code_and_decode_unit_tb;

  localparam int NoIdx = 63;

  typedef struct {
    htcd_pkg::in_beat_t  req;
    bit                  typed;
    htcd_pkg::out_beat_t res;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  htcd_pkg::in_beat_t  in_beat;
  logic                out_valid;
  htcd_pkg::out_beat_t out_beat;

  // Predictor state: node tables, leaf count, walk cursor and the code table of the last build.
  int unsigned node_w[htcd_pkg::NodeCount];
  int          node_up[htcd_pkg::NodeCount];
  int          node_lo[htcd_pkg::NodeCount];
  int          node_hi[htcd_pkg::NodeCount];
  int          leaves;
  int          cursor;
  bit          tree_built;
  bit          set_open;
  int          sym_code[htcd_pkg::MaxSymbols];
  int          sym_len[htcd_pkg::MaxSymbols];

  htcd_pkg::out_beat_t beat_results[$];
  htcd_pkg::out_beat_t pending_results[$];
  stim_row_t           dir_rows[$];
  int                  mismatches;
  int                  beats_sent;
  bit                  idle_ok;

  huffman_tree_code_and_decode_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_beat (out_beat)
  );

  // Clock, 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic htcd_pkg::in_beat_t mk(input logic rt, input int w, input logic cb,
                                            input logic lst);
    htcd_pkg::in_beat_t b;
    b.req_type = rt;
    b.weight   = w[15:0];
    b.code_bit = cb;
    b.last     = lst;
    return b;
  endfunction

  function automatic htcd_pkg::out_beat_t res_of(input logic [1:0] k, input int s, input int w,
                                                 input int l, input logic fin);
    htcd_pkg::out_beat_t r;
    r.kind         = k;
    r.symbol       = s[3:0];
    r.code_word    = w[14:0];
    r.code_length  = l[3:0];
    r.final_result = fin;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input htcd_pkg::in_beat_t req, input bit typed,
                                  input htcd_pkg::out_beat_t res);
    stim_row_t row;
    row.req   = req;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < htcd_pkg::NodeCount; i++) begin
      node_w[i]  = 0;
      node_up[i] = NoIdx;
      node_lo[i] = NoIdx;
      node_hi[i] = NoIdx;
    end
  endfunction

  // Merge the two lightest parentless nodes until one root remains.
  function automatic void build_tree();
    bit h1, h2;
    int a, b;
    int unsigned w1, w2;
    for (int i = 0; i + 1 < leaves; i++) begin
      h1 = 0; h2 = 0; a = 0; b = 0; w1 = 0; w2 = 0;
      for (int j = 0; j < leaves + i; j++) begin
        if (node_up[j] != NoIdx) continue;
        if (!h1 || node_w[j] < w1) begin
          b = a; w2 = w1; h2 = h1;
          a = j; w1 = node_w[j]; h1 = 1;
        end else if (!h2 || node_w[j] < w2) begin
          b = j; w2 = node_w[j]; h2 = 1;
        end
      end
      node_up[a] = leaves + i;
      node_up[b] = leaves + i;
      node_w[leaves + i]  = w1 + w2;
      node_lo[leaves + i] = a;
      node_hi[leaves + i] = b;
    end
  endfunction

  // Work out the result beats of one accepted request into beat_results.
  function automatic void predict_beat(input htcd_pkg::in_beat_t b);
    int root, c, nx, child, len, word;
    beat_results.delete();
    root = 2 * leaves - 2;
    if (b.req_type == htcd_pkg::ReqLoad) begin
      if (!set_open) begin
        clear_tree();
        leaves = 0; cursor = 0; tree_built = 0; set_open = 1;
      end
      if (leaves < htcd_pkg::MaxSymbols) begin
        node_w[leaves] = b.weight;
        leaves++;
      end
      if (!b.last) return;
      set_open = 0;
      build_tree();
      tree_built = 1;
      cursor = 2 * leaves - 2;
      for (int s = 0; s < leaves; s++) begin
        child = s; len = 0; word = 0;
        while (node_up[child] != NoIdx) begin
          if (node_hi[node_up[child]] == child && node_lo[node_up[child]] != child)
            word |= 1 << len;
          len++;
          child = node_up[child];
        end
        sym_code[s] = word;
        sym_len[s]  = len;
        beat_results.insert(beat_results.size(),
                            res_of(htcd_pkg::KindCode, s, word, len, 1'b0));
      end
    end else if (!tree_built || set_open) begin
      beat_results.insert(beat_results.size(), res_of(htcd_pkg::KindErr, 0, 0, 0, 1'b0));
    end else begin
      if (leaves == 1) begin
        beat_results.insert(beat_results.size(), res_of(htcd_pkg::KindSym, 0, 0, 0, 1'b0));
      end else begin
        c = cursor;
        if (c >= htcd_pkg::NodeCount) c = root;
        nx = b.code_bit ? node_hi[c] : node_lo[c];
        if (nx >= htcd_pkg::NodeCount) nx = root;
        if (nx < leaves) begin
          beat_results.insert(beat_results.size(),
                              res_of(htcd_pkg::KindSym, nx, 0, 0, 1'b0));
          cursor = root;
        end else begin
          cursor = nx;
        end
      end
      if (b.last) begin
        if (leaves == 1 || cursor == root)
          beat_results.insert(beat_results.size(), res_of(htcd_pkg::KindOk, 0, 0, 0, 1'b0));
        else
          beat_results.insert(beat_results.size(), res_of(htcd_pkg::KindErr, 0, 0, 0, 1'b0));
        cursor = root;
      end
    end
    if (beat_results.size() > 0) beat_results[$].final_result = 1'b1;
  endfunction

  // Present one beat, hold it until taken, then queue what it should cause.
  task automatic send_beat(input htcd_pkg::in_beat_t b, input bit typed,
                           input htcd_pkg::out_beat_t res);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_beat(b);
    if (typed) pending_results.insert(pending_results.size(), res);
    else foreach (beat_results[i]) pending_results.insert(pending_results.size(), beat_results[i]);
    beats_sent++;
  endtask

  task automatic send_plain(input htcd_pkg::in_beat_t b);
    send_beat(b, 1'b0, '0);
  endtask

  // Check each result beat against the oldest expected one.
  always @(posedge clk) begin
    htcd_pkg::out_beat_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = pending_results.pop_front();
        if (out_beat.kind != e.kind)
          report($sformatf("kind %0d, expected %0d", out_beat.kind, e.kind));
        if (out_beat.symbol != e.symbol)
          report($sformatf("symbol %0d, expected %0d", out_beat.symbol, e.symbol));
        if (out_beat.code_word != e.code_word)
          report($sformatf("code_word %h, expected %h", out_beat.code_word, e.code_word));
        if (out_beat.code_length != e.code_length)
          report($sformatf("code_length %0d, expected %0d", out_beat.code_length,
                           e.code_length));
        if (out_beat.final_result != e.final_result)
          report($sformatf("final_result %0b, expected %0b", out_beat.final_result,
                           e.final_result));
      end
    end
  end

  // Stimulus: reset, directed table, random sets with decode sequences.
  initial begin
    stim_row_t r;
    int n, nsym, s, cut;
    int bits[$];
    rst_n      = 1'b0;
    start      = 1'b0;
    in_beat    = '0;
    mismatches = 0;
    beats_sent = 0;
    idle_ok    = 1'b1;
    leaves     = 0;
    cursor     = 0;
    tree_built = 0;
    set_open   = 0;
    clear_tree();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decode with no tree, single-symbol set, open set, extremes, too many leaves.
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b0, 1'b0), 1'b1,
            res_of(htcd_pkg::KindErr, 0, 0, 0, 1'b1));
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b1, 1'b1), 1'b1,
            res_of(htcd_pkg::KindErr, 0, 0, 0, 1'b1));
    add_row(mk(htcd_pkg::ReqLoad, 65535, 1'b0, 1'b1), 1'b1,
            res_of(htcd_pkg::KindCode, 0, 0, 0, 1'b1));
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b0, 1'b0), 1'b1,
            res_of(htcd_pkg::KindSym, 0, 0, 0, 1'b1));
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b1, 1'b1), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqLoad, 0, 1'b1, 1'b0), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b0, 1'b1), 1'b1,
            res_of(htcd_pkg::KindErr, 0, 0, 0, 1'b1));
    add_row(mk(htcd_pkg::ReqLoad, 65535, 1'b0, 1'b1), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b0, 1'b0), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b1, 1'b1), 1'b0, '0);
    for (int i = 0; i < 17; i++)
      add_row(mk(htcd_pkg::ReqLoad, i * 3, 1'b0, i == 16), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b0, 1'b1), 1'b0, '0);
    add_row(mk(htcd_pkg::ReqDecode, 0, 1'b1, 1'b0), 1'b0, '0);
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_beat(r.req, r.typed, r.res);
    end

    // Random sets, each followed by a few decode sequences.
    while (beats_sent < 460) begin
      if (beats_sent >= 400) idle_ok = 1'b0;
      case ($urandom_range(0, 9))
        0:       n = 1;
        1:       n = $urandom_range(15, 18);
        default: n = $urandom_range(2, 8);
      endcase
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 12) == 0)
          send_plain(mk(htcd_pkg::ReqDecode, int'($urandom), 1'($urandom), 1'($urandom)));
        send_plain(mk(htcd_pkg::ReqLoad, $urandom_range(0, 1) ? int'($urandom_range(0, 65535))
                              : int'($urandom_range(0, 4)), 1'($urandom), i == n - 1));
      end
      repeat ($urandom_range(2, 5)) begin
        if (beats_sent >= 460) break;
        bits.delete();
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 8)) bits.insert(bits.size(), int'($urandom_range(0, 1)));
        end else if (leaves == 1) begin
          repeat ($urandom_range(1, 3)) bits.insert(bits.size(), int'($urandom_range(0, 1)));
        end else begin
          nsym = $urandom_range(1, 4);
          repeat (nsym) begin
            s = $urandom_range(0, leaves - 1);
            for (int k = sym_len[s] - 1; k >= 0; k--)
              bits.insert(bits.size(), (sym_code[s] >> k) & 1);
          end
          // A broken sequence is cut short by dropping bits from its end.
          if ($urandom_range(0, 5) == 0 && bits.size() > 1) begin
            cut = $urandom_range(1, bits.size() - 1);
            repeat (cut) void'(bits.pop_back());
          end
        end
        foreach (bits[i])
          send_plain(mk(htcd_pkg::ReqDecode, int'($urandom), bits[i][0],
                        i == bits.size() - 1));
      end
    end

    // Drain: wait for every expected beat, then watch for strays.
    start <= 1'b0;
    for (int i = 0; i < 20000 && pending_results.size() > 0; i++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending_results.size() > 0)
      report($sformatf("%0d expected result beats never came", pending_results.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3200000;
    $display("FAILURE");
    $finish;
  end
endmodule
